[design/tbee_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tbee_pkg;

  // Effect mode codes, shared by the mode register and the running effect.
  localparam logic [2:0] MODE_STATIC = 3'd0;
  localparam logic [2:0] MODE_FLASH  = 3'd1;
  localparam logic [2:0] MODE_BURST  = 3'd2;
  localparam logic [2:0] MODE_LINEAR = 3'd3;
  localparam logic [2:0] MODE_BEZIER = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_EFFECT_MODE  = 3'd0;
  localparam logic [2:0] CFG_FIRST_LEVEL  = 3'd1;
  localparam logic [2:0] CFG_SECOND_LEVEL = 3'd2;
  localparam logic [2:0] CFG_FIRST_TIME   = 3'd3;
  localparam logic [2:0] CFG_AUX_TIME     = 3'd4;
  localparam logic [2:0] CFG_COUNT_OR_Y1  = 3'd5;
  localparam logic [2:0] CFG_CTRL_Y2      = 3'd6;

  // Ramp levels are held to 0..LEVEL_CAP.
  localparam logic [7:0] LEVEL_CAP = 8'd100;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        restart;
  } in_t;

  typedef struct packed {
    logic [7:0] level;
    logic       finished;
  } out_t;

  // Which division the shared divider performs.
  typedef enum logic {
    DIV_STEPS = 1'b0,
    DIV_CURVE = 1'b1
  } div_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accept;
    logic     latch_time;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_steps;
    logic     advance;
    logic     take_t;
    logic     mul_uv;
    logic     mul_sum;
    logic     mul_b;
    logic     take_bz;
    logic     mul_prod;
    logic     finish_curve;
    logic     emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;
    logic same_time;
    logic is_static;
    logic div_busy;
    logic div_done;
    logic zero_steps;
    logic curve_more;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/timed_brightness_effect_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Brightness effect engine: each input transfer carries a millisecond
// timestamp (and an optional restart that reloads the effect from the
// configuration registers), and each one yields exactly one output transfer
// with the current level and a finished flag. One tick is handled at a time.
// A tick that only latches time or finds nothing to do goes straight to
// output. A tick that advances the effect divides the elapsed time by the
// step period, and a Bezier step also divides the curve position by its
// length, both in one shared radix-2 divider; the curve then runs through a
// chain of multiplies, the final scaling by 100 done as a reciprocal multiply.
// A result waiting in the output register holds back the following tick's
// result until it is taken. The user must write configuration through the
// plain write port only while the engine is idle; the block does not enforce
// it. The output register lets the next tick be taken while a result waits.
module timed_brightness_effect_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire tbee_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output tbee_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [7:0]     cfg_data
);

  tbee_pkg::cmd_t cmd;
  tbee_pkg::sts_t sts;

  tbee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tbee_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

[design/tbee_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbee_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [11:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [11:0]      remainder
);

  logic [11:0] dvsr;
  logic [4:0]  cnt;
  logic [12:0] shifted;
  logic        ge;
  logic [12:0] diff;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign shifted = {remainder, quotient[31]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  // Control: 32 steps after start, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr      <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[30:0], ge};
      remainder <= ge ? diff[11:0] : shifted[11:0];
    end
  end

endmodule

`default_nettype wire

[design/tbee_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbee_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tbee_pkg::sts_t sts,
  output tbee_pkg::cmd_t     cmd
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_CHECK   = 13'b0000000000010,
    S_SDIV    = 13'b0000000000100,
    S_ADV     = 13'b0000000001000,
    S_TSTART  = 13'b0000000010000,
    S_TWAIT   = 13'b0000000100000,
    S_MUV     = 13'b0000001000000,
    S_MSUM    = 13'b0000010000000,
    S_MB      = 13'b0000100000000,
    S_SCALE   = 13'b0001000000000,
    S_MPROD   = 13'b0010000000000,
    S_FIN     = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequencing of one tick.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = tbee_pkg::DIV_STEPS;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.started) begin
          cmd.latch_time = 1'b1;
          state_next     = S_OUT;
        end else if (!sts.same_time && !sts.is_static) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = tbee_pkg::DIV_STEPS;
          state_next    = S_SDIV;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SDIV: begin
        if (sts.div_done) begin
          if (sts.zero_steps) begin
            state_next = S_OUT;
          end else begin
            cmd.take_steps = 1'b1;
            state_next     = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        state_next  = sts.curve_more ? S_TSTART : S_OUT;
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tbee_pkg::DIV_CURVE;
        state_next    = S_TWAIT;
      end
      S_TWAIT: begin
        if (sts.div_done) begin
          cmd.take_t = 1'b1;
          state_next = S_MUV;
        end
      end
      S_MUV: begin
        cmd.mul_uv = 1'b1;
        state_next = S_MSUM;
      end
      S_MSUM: begin
        cmd.mul_sum = 1'b1;
        state_next  = S_MB;
      end
      S_MB: begin
        cmd.mul_b  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.take_bz = 1'b1;
        state_next  = S_MPROD;
      end
      S_MPROD: begin
        cmd.mul_prod = 1'b1;
        state_next   = S_FIN;
      end
      S_FIN: begin
        cmd.finish_curve = 1'b1;
        state_next       = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The divider is only started when it is free.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result overwrote a pending transfer");

  // A division completes only while the controller waits for one.
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    sts.div_done |-> (state == S_SDIV || state == S_TWAIT))
    else $error("unexpected divider completion");

endmodule

`default_nettype wire

[design/tbee_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module tbee_dp (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tbee_pkg::in_t  in_data,
  input  wire logic           out_ready,
  output logic                out_valid,
  output tbee_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [7:0]     cfg_data,
  input  wire tbee_pkg::cmd_t cmd,
  output tbee_pkg::sts_t      sts
);

  // ceil(2^35 / 100); floor(x * RECIP_100 / 2^35) equals floor(x / 100) for x below 2^30.
  localparam logic [28:0] RECIP_100 = 29'd343597384;

  function automatic logic [7:0] clamp_cap(input logic [7:0] v);
    clamp_cap = (v > tbee_pkg::LEVEL_CAP) ? tbee_pkg::LEVEL_CAP : v;
  endfunction

  // Configuration registers.
  logic [2:0] cfg_mode;
  logic [7:0] cfg_first_level, cfg_second_level, cfg_first_time;
  logic [7:0] cfg_aux_time, cfg_count_y1, cfg_ctrl_y2;

  // Effect state.
  logic [7:0]  current_level, ramp_start, ramp_target;
  logic [2:0]  active_mode;
  logic [31:0] last_step_time;
  logic        started;
  logic [7:0]  period_now, period_other, bursts_left;
  logic [15:0] curve_position;
  logic [11:0] curve_length;
  logic [7:0]  held_y1, held_y2;

  // Per-tick working registers.
  logic [31:0] now_reg;
  logic [31:0] steps;
  logic [15:0] t;
  logic [33:0] uu;
  logic [32:0] ut;
  logic [31:0] tt;
  logic [43:0] s_sum;
  logic [59:0] bprod;
  logic [21:0] bz;
  logic signed [31:0] prod;

  // Divider connection.
  logic        div_busy, div_done;
  logic [31:0] div_quo, div_dividend;
  logic [11:0] div_rem, div_divisor;

  always_comb begin
    unique case (cmd.div_sel)
      tbee_pkg::DIV_STEPS: begin
        div_dividend = now_reg - last_step_time;
        div_divisor  = {4'b0, (period_now == 8'd0) ? 8'd1 : period_now};
      end
      tbee_pkg::DIV_CURVE: begin
        div_dividend = {curve_position, 16'b0};
        div_divisor  = curve_length;
      end
    endcase
  end

  tbee_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Linear ramp step.
  logic [32:0] up_sum;
  logic        up_settle;
  logic        dn_neg;
  logic [7:0]  dn_val;
  logic        dn_settle;
  logic        rising;

  assign rising    = current_level < ramp_target;
  assign up_sum    = {25'b0, current_level} + {1'b0, steps};
  assign up_settle = (up_sum >= {25'b0, ramp_target}) || (up_sum > 33'd100);
  assign dn_neg    = steps > {24'b0, current_level};
  assign dn_val    = current_level - steps[7:0];
  assign dn_settle = dn_neg || (dn_val <= ramp_target);

  // Curve position, saturating at its top.
  logic [16:0] pos_sum;
  logic [15:0] pos_new;
  logic        pos_end;

  assign pos_sum = {1'b0, curve_position} + {1'b0, steps[15:0]};
  assign pos_new = ((|steps[31:16]) || pos_sum[16]) ? 16'hFFFF : pos_sum[15:0];
  assign pos_end = pos_new >= {4'b0, curve_length};

  // Bezier arithmetic: u = 1 - t in Q16, weights 3*y1, 3*y2 and 100.
  logic [16:0] u;
  logic [9:0]  y1x3, y2x3;
  logic [33:0] uu_w;
  logic [32:0] ut_w;
  logic [31:0] tt_w;
  logic [43:0] s_w;
  logic [59:0] b_w;
  logic [56:0] scale_w;
  logic signed [8:0]  delta;
  logic signed [31:0] prod_w;
  logic signed [17:0] curve_sum;
  logic [7:0]  curve_level;

  assign u      = 17'h10000 - {1'b0, t};
  assign y1x3   = {1'b0, held_y1, 1'b0} + {2'b0, held_y1};
  assign y2x3   = {1'b0, held_y2, 1'b0} + {2'b0, held_y2};
  assign uu_w   = u * u;
  assign ut_w   = u * t;
  assign tt_w   = t * t;
  assign s_w    = ({10'b0, uu} * {34'b0, y1x3}) + ({11'b0, ut} * {34'b0, y2x3})
                + ({12'b0, tt} * 44'd100);
  assign b_w    = s_sum * t;
  // Dropping the low 32 bits first and then dividing by 100 gives the same floor.
  assign scale_w = {29'b0, bprod[59:32]} * {28'b0, RECIP_100};
  assign delta  = $signed({1'b0, ramp_target}) - $signed({1'b0, ramp_start});
  assign prod_w = $signed({1'b0, bz}) * delta;
  assign curve_sum = $signed({10'b0, ramp_start}) + {{2{prod[31]}}, prod[31:16]};

  always_comb begin
    if (curve_sum < 0) begin
      curve_level = 8'd0;
    end else if (curve_sum > 18'sd100) begin
      curve_level = tbee_pkg::LEVEL_CAP;
    end else begin
      curve_level = curve_sum[7:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_mode         <= '0;
      cfg_first_level  <= '0;
      cfg_second_level <= '0;
      cfg_first_time   <= '0;
      cfg_aux_time     <= '0;
      cfg_count_y1     <= '0;
      cfg_ctrl_y2      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbee_pkg::CFG_EFFECT_MODE:  cfg_mode         <= cfg_data[2:0];
        tbee_pkg::CFG_FIRST_LEVEL:  cfg_first_level  <= cfg_data;
        tbee_pkg::CFG_SECOND_LEVEL: cfg_second_level <= cfg_data;
        tbee_pkg::CFG_FIRST_TIME:   cfg_first_time   <= cfg_data;
        tbee_pkg::CFG_AUX_TIME:     cfg_aux_time     <= cfg_data;
        tbee_pkg::CFG_COUNT_OR_Y1:  cfg_count_y1     <= cfg_data;
        tbee_pkg::CFG_CTRL_Y2:      cfg_ctrl_y2      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effect state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level  <= '0;
      ramp_start     <= '0;
      ramp_target    <= '0;
      active_mode    <= tbee_pkg::MODE_STATIC;
      last_step_time <= '0;
      started        <= 1'b0;
      period_now     <= '0;
      period_other   <= '0;
      bursts_left    <= '0;
      curve_position <= '0;
      curve_length   <= '0;
      held_y1        <= '0;
      held_y2        <= '0;
    end else if (cmd.accept) begin
      if (in_data.restart) begin
        // Reload the effect; the time base starts over on this tick.
        current_level  <= cfg_first_level;
        ramp_start     <= cfg_first_level;
        ramp_target    <= cfg_second_level;
        period_now     <= cfg_first_time;
        period_other   <= '0;
        bursts_left    <= '0;
        curve_position <= '0;
        curve_length   <= '0;
        held_y1        <= '0;
        held_y2        <= '0;
        started        <= 1'b0;
        last_step_time <= '0;
        if (cfg_mode == tbee_pkg::MODE_BURST) begin
          period_other <= cfg_aux_time;
          bursts_left  <= cfg_count_y1;
          active_mode  <= tbee_pkg::MODE_BURST;
        end else if (cfg_mode == tbee_pkg::MODE_FLASH || cfg_mode == tbee_pkg::MODE_LINEAR
                     || cfg_mode == tbee_pkg::MODE_BEZIER) begin
          active_mode <= cfg_mode;
          if (cfg_mode == tbee_pkg::MODE_BEZIER) begin
            curve_length <= {1'b0, cfg_aux_time, 3'b0} + {3'b0, cfg_aux_time, 1'b0};
            held_y1      <= cfg_count_y1;
            held_y2      <= cfg_ctrl_y2;
          end
          if (cfg_first_time == 8'd0) begin
            current_level <= cfg_second_level;
            active_mode   <= tbee_pkg::MODE_STATIC;
          end
        end else begin
          active_mode <= tbee_pkg::MODE_STATIC;
        end
      end
    end else if (cmd.latch_time) begin
      started        <= 1'b1;
      last_step_time <= now_reg;
    end else if (cmd.take_steps) begin
      // last + steps * period equals now less the remainder.
      last_step_time <= now_reg - {20'b0, div_rem};
    end else if (cmd.advance) begin
      unique case (active_mode)
        tbee_pkg::MODE_FLASH: begin
          current_level <= ramp_target;
          active_mode   <= tbee_pkg::MODE_STATIC;
        end
        tbee_pkg::MODE_BURST: begin
          if (bursts_left == 8'd0) begin
            active_mode <= tbee_pkg::MODE_STATIC;
          end else begin
            if (current_level == ramp_start) begin
              current_level <= ramp_target;
              bursts_left   <= bursts_left - 8'd1;
            end else begin
              current_level <= ramp_start;
            end
            period_now   <= period_other;
            period_other <= period_now;
          end
        end
        tbee_pkg::MODE_LINEAR: begin
          if (rising) begin
            if (up_settle) begin
              current_level <= clamp_cap(ramp_target);
              active_mode   <= tbee_pkg::MODE_STATIC;
            end else begin
              current_level <= up_sum[7:0];
            end
          end else begin
            if (dn_settle) begin
              current_level <= clamp_cap(ramp_target);
              active_mode   <= tbee_pkg::MODE_STATIC;
            end else begin
              current_level <= clamp_cap(dn_val);
            end
          end
        end
        tbee_pkg::MODE_BEZIER: begin
          curve_position <= pos_new;
          if (pos_end) begin
            current_level <= clamp_cap(ramp_target);
            active_mode   <= tbee_pkg::MODE_STATIC;
          end
        end
        default: begin
          active_mode <= tbee_pkg::MODE_STATIC;
        end
      endcase
    end else if (cmd.finish_curve) begin
      current_level <= curve_level;
    end
  end

  // Working registers of one tick.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      now_reg <= in_data.now_ms;
    end
    if (cmd.take_steps) begin
      steps <= div_quo;
    end
    if (cmd.take_t) begin
      t <= div_quo[15:0];
    end
    if (cmd.mul_uv) begin
      uu <= uu_w;
      ut <= ut_w;
      tt <= tt_w;
    end
    if (cmd.mul_sum) begin
      s_sum <= s_w;
    end
    if (cmd.mul_b) begin
      bprod <= b_w;
    end
    if (cmd.take_bz) begin
      bz <= scale_w[56:35];
    end
    if (cmd.mul_prod) begin
      prod <= prod_w;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.level    <= current_level;
      out_data.finished <= (active_mode == tbee_pkg::MODE_STATIC);
    end
  end

  // Status to the controller.
  always_comb begin
    sts.started    = started;
    sts.same_time  = (now_reg == last_step_time);
    sts.is_static  = (active_mode == tbee_pkg::MODE_STATIC);
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.zero_steps = (div_quo == 32'd0);
    sts.curve_more = (active_mode == tbee_pkg::MODE_BEZIER) && !pos_end;
    sts.out_free   = !out_valid || out_ready;
  end

  // A linear ramp step never leaves the level above the cap.
  a_linear_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.advance && active_mode == tbee_pkg::MODE_LINEAR |=>
      current_level <= tbee_pkg::LEVEL_CAP)
    else $error("linear ramp level above cap");

  // Steps are only taken when the division gave at least one.
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.take_steps |-> div_quo != 32'd0)
    else $error("zero steps applied");

endmodule

`default_nettype wire
